>>> rtl/core/multichannel_biquad_filter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel biquad filter core
// Shorthand for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_BIQUAD_FILTER_CORE_MACROS_SVH
`define MULTICHANNEL_BIQUAD_FILTER_CORE_MACROS_SVH

// Same-cycle implication: cons holds whenever ante holds.
`define MBF_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons holds in the cycle after ante.
`define MBF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mbf_pkg.sv
// ----------------------------------------------------------------------------
// mbf_pkg
// Shared constants, codes and control structs of the biquad filter core.
// ----------------------------------------------------------------------------
package mbf_pkg;

  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_SAMPLE_WIDTH = 24;
  localparam int DEF_COEF_WIDTH   = 32;

  localparam int CH_W    = 3;   // channel tag width
  localparam int STATE_W = 40;  // Q10.30 state and saturated accumulator
  localparam int ACC_W   = 46;  // exact sum of three products before saturation
  localparam int TQ_W    = 43;  // magnitude of one truncated product
  localparam int ACT_W   = 4;
  localparam int THR_W   = 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int NUM_PROD = 5;

  localparam logic [THR_W-1:0] DEF_FLUSH = 16'd10;

  // product codes; also the slot order of the coefficient bank
  localparam logic [2:0] P_A1 = 3'd0;
  localparam logic [2:0] P_A2 = 3'd1;
  localparam logic [2:0] P_B0 = 3'd2;
  localparam logic [2:0] P_B1 = 3'd3;
  localparam logic [2:0] P_B2 = 3'd4;

  // register indexes
  localparam logic [2:0] REG_B0  = 3'd0;
  localparam logic [2:0] REG_B1  = 3'd1;
  localparam logic [2:0] REG_B2  = 3'd2;
  localparam logic [2:0] REG_A1  = 3'd3;
  localparam logic [2:0] REG_A2  = 3'd4;
  localparam logic [2:0] REG_ACT = 3'd5;
  localparam logic [2:0] REG_THR = 3'd6;

  typedef struct packed {
    logic       load_in;
    logic       load_state;
    logic       mag;
    logic       mul_lo;
    logic       mul_hi;
    logic       sum;
    logic       add;
    logic [2:0] sel;
    logic       sat_w;
    logic       sat_y;
    logic       out_load;
  } mbf_cmd_t;

  typedef struct packed {
    logic in_active;
    logic out_free;
  } mbf_status_t;

endpackage

>>> rtl/core/mbf_regs.sv
// ----------------------------------------------------------------------------
// mbf_regs
// APB register bank: coefficients, active channel count, flush threshold.
// ----------------------------------------------------------------------------
module mbf_regs import mbf_pkg::*; #(
  parameter int COEF_WIDTH = DEF_COEF_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ADDR_W-1:0]                 paddr,
  input  logic [DATA_W-1:0]                 pwdata,
  output logic [DATA_W-1:0]                 prdata,
  output logic                              pready,
  output logic [NUM_PROD-1:0][COEF_WIDTH-1:0] coefs,
  output logic [ACT_W-1:0]                  active_channels,
  output logic [THR_W-1:0]                  flush_threshold
);

  localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << (COEF_WIDTH - 4);

  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs[P_A1]     <= '0;
      coefs[P_A2]     <= '0;
      coefs[P_B0]     <= COEF_ONE;
      coefs[P_B1]     <= '0;
      coefs[P_B2]     <= '0;
      active_channels <= '0;
      flush_threshold <= DEF_FLUSH;
    end else if (wr_en) begin
      unique case (idx)
        REG_B0:  coefs[P_B0] <= pwdata[COEF_WIDTH-1:0];
        REG_B1:  coefs[P_B1] <= pwdata[COEF_WIDTH-1:0];
        REG_B2:  coefs[P_B2] <= pwdata[COEF_WIDTH-1:0];
        REG_A1:  coefs[P_A1] <= pwdata[COEF_WIDTH-1:0];
        REG_A2:  coefs[P_A2] <= pwdata[COEF_WIDTH-1:0];
        REG_ACT: active_channels <= pwdata[ACT_W-1:0];
        REG_THR: flush_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_B0:  prdata = DATA_W'($signed(coefs[P_B0]));
      REG_B1:  prdata = DATA_W'($signed(coefs[P_B1]));
      REG_B2:  prdata = DATA_W'($signed(coefs[P_B2]));
      REG_A1:  prdata = DATA_W'($signed(coefs[P_A1]));
      REG_A2:  prdata = DATA_W'($signed(coefs[P_A2]));
      REG_ACT: prdata = DATA_W'(active_channels);
      REG_THR: prdata = DATA_W'(flush_threshold);
      default: prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/mbf_dp.sv
// ----------------------------------------------------------------------------
// mbf_dp
// Biquad datapath: state memory, shared multiplier, accumulator, output stage.
// ----------------------------------------------------------------------------
module mbf_dp import mbf_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mbf_cmd_t                            cmd,
  output mbf_status_t                         status,
  input  logic [NUM_PROD-1:0][COEF_WIDTH-1:0] coefs,
  input  logic [ACT_W-1:0]                    active_channels,
  input  logic [THR_W-1:0]                    flush_threshold,
  input  logic [CH_W-1:0]                     in_ch,
  input  logic [SAMPLE_WIDTH-1:0]             in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [CH_W-1:0]                     out_ch,
  output logic [SAMPLE_WIDTH-1:0]             out_sample
);

  localparam int IDX_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FRAC     = COEF_WIDTH - 4;
  localparam int IN_SHIFT = (SAMPLE_WIDTH <= 31) ? 31 - SAMPLE_WIDTH : 0;
  localparam int HALF     = (IN_SHIFT > 0) ? (1 << IN_SHIFT) >> 1 : 0;
  localparam int FULL_W   = COEF_WIDTH + 41;
  localparam int R_W      = 42;

  localparam logic signed [ACC_W-1:0] S40_MAX = (ACC_W'(1) <<< (STATE_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S40_MIN = -S40_MAX - ACC_W'(1);
  localparam logic signed [R_W-1:0]   SMP_MAX = (R_W'(1) <<< (SAMPLE_WIDTH - 1)) - R_W'(1);
  localparam logic signed [R_W-1:0]   SMP_MIN = -SMP_MAX - R_W'(1);

  // state memory: {w1, w2} per channel, valid bits stand in for the reset clear
  logic [2*STATE_W-1:0]     mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0]  valid;
  logic [2*STATE_W-1:0]     rd_word;
  logic                     rd_ok;

  logic [IDX_W-1:0]                in_idx;
  logic [IDX_W-1:0]                idx_r;
  logic [CH_W-1:0]                 ch_r;
  logic signed [SAMPLE_WIDTH-1:0]  x_r;
  logic signed [STATE_W-1:0]       w1_r;
  logic signed [STATE_W-1:0]       w2_r;
  logic signed [STATE_W-1:0]       w_r;
  logic signed [ACC_W-1:0]         acc;
  logic [COEF_WIDTH-1:0]           mag_c;
  logic [STATE_W-1:0]              mag_s;
  logic                            neg_r;
  logic                            sub_r;
  logic [COEF_WIDTH+31:0]          plo;
  logic [COEF_WIDTH+7:0]           phi;
  logic [TQ_W-1:0]                 tq_r;
  logic [SAMPLE_WIDTH-1:0]         y_r;

  logic [COEF_WIDTH-1:0]           c_sel;
  logic signed [STATE_W-1:0]       s_sel;
  logic                            sub_sel;
  logic [FULL_W-1:0]               full;
  logic signed [ACC_W-1:0]         term;
  logic signed [ACC_W-1:0]         x_scaled;
  logic signed [STATE_W-1:0]       acc40;
  logic signed [STATE_W:0]         acc_abs;
  logic signed [R_W-1:0]           r;
  logic [SAMPLE_WIDTH-1:0]         y_next;

  function automatic logic signed [STATE_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
    if (v > S40_MAX) begin
      return STATE_W'(S40_MAX);
    end else if (v < S40_MIN) begin
      return STATE_W'(S40_MIN);
    end
    return STATE_W'(v);
  endfunction

  assign in_idx = IDX_W'(in_ch);
  assign status.in_active = ({1'b0, in_ch} < active_channels) && (int'(in_ch) < MAX_CHANNELS);
  assign status.out_free  = !out_valid || out_ready;

  // operand select
  always_comb begin
    unique case (cmd.sel)
      P_A1:    begin c_sel = coefs[P_A1]; s_sel = w1_r; sub_sel = 1'b1; end
      P_A2:    begin c_sel = coefs[P_A2]; s_sel = w2_r; sub_sel = 1'b1; end
      P_B0:    begin c_sel = coefs[P_B0]; s_sel = w_r;  sub_sel = 1'b0; end
      P_B1:    begin c_sel = coefs[P_B1]; s_sel = w1_r; sub_sel = 1'b0; end
      P_B2:    begin c_sel = coefs[P_B2]; s_sel = w2_r; sub_sel = 1'b0; end
      default: begin c_sel = '0;          s_sel = '0;   sub_sel = 1'b0; end
    endcase
  end

  assign full = {1'b0, phi, 32'd0} + FULL_W'(plo);
  assign term = $signed(ACC_W'(tq_r));

  always_comb begin
    if (SAMPLE_WIDTH <= 31) begin
      x_scaled = ACC_W'(x_r) <<< IN_SHIFT;
    end else begin
      x_scaled = ACC_W'(x_r) >>> 1;
    end
  end

  // output conversion: flush to zero at or below the threshold, else round to nearest, ties up, then saturate
  assign acc40   = sat40(acc);
  assign acc_abs = acc40[STATE_W-1] ? -(STATE_W+1)'(acc40) : (STATE_W+1)'(acc40);

  always_comb begin
    if (SAMPLE_WIDTH <= 31) begin
      r = (R_W'(acc40) + R_W'(HALF)) >>> IN_SHIFT;
    end else begin
      r = R_W'(acc40) <<< 1;
    end
    if (acc_abs <= $signed((STATE_W+1)'(flush_threshold))) begin
      y_next = '0;
    end else if (r > SMP_MAX) begin
      y_next = SAMPLE_WIDTH'(SMP_MAX);
    end else if (r < SMP_MIN) begin
      y_next = SAMPLE_WIDTH'(SMP_MIN);
    end else begin
      y_next = r[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in && status.in_active) begin
      rd_word <= mem[in_idx];
      rd_ok   <= valid[in_idx];
    end
    if (cmd.sat_y) begin
      mem[idx_r] <= {w_r, w1_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.sat_y) begin
      valid[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch_r  <= in_ch;
      idx_r <= in_idx;
      x_r   <= in_sample;
      y_r   <= in_sample;  // pass-through value unless filtered
    end
    if (cmd.load_state) begin
      w1_r <= rd_ok ? rd_word[2*STATE_W-1:STATE_W] : '0;
      w2_r <= rd_ok ? rd_word[STATE_W-1:0] : '0;
      acc  <= x_scaled;
    end
    if (cmd.mag) begin
      mag_c <= c_sel[COEF_WIDTH-1] ? (~c_sel + COEF_WIDTH'(1)) : c_sel;
      mag_s <= s_sel[STATE_W-1] ? STATE_W'(-s_sel) : STATE_W'(s_sel);
      neg_r <= c_sel[COEF_WIDTH-1] ^ s_sel[STATE_W-1];
      sub_r <= sub_sel;
    end
    if (cmd.mul_lo) begin
      plo <= mag_c * mag_s[31:0];
    end
    if (cmd.mul_hi) begin
      phi <= mag_c * mag_s[STATE_W-1:32];
    end
    if (cmd.sum) begin
      tq_r <= TQ_W'(full >> FRAC);
    end
    if (cmd.add) begin
      acc <= (neg_r ^ sub_r) ? acc - term : acc + term;
    end
    if (cmd.sat_w) begin
      w_r <= acc40;
      acc <= '0;
    end
    if (cmd.sat_y) begin
      y_r <= y_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch     <= ch_r;
      out_sample <= y_r;
    end
  end

endmodule

>>> rtl/core/mbf_ctrl.sv
// ----------------------------------------------------------------------------
// mbf_ctrl
// Sequencer that steps the datapath through the five products of one sample.
// ----------------------------------------------------------------------------
`include "multichannel_biquad_filter_core_macros.svh"

module mbf_ctrl import mbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  mbf_status_t status,
  output mbf_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_MAG  = 4'd2;
  localparam logic [3:0] ST_MLO  = 4'd3;
  localparam logic [3:0] ST_MHI  = 4'd4;
  localparam logic [3:0] ST_SUM  = 4'd5;
  localparam logic [3:0] ST_ADD  = 4'd6;
  localparam logic [3:0] ST_SATW = 4'd7;
  localparam logic [3:0] ST_SATY = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] sel;
  logic [2:0] sel_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    sel_next   = sel;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.in_active ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: begin
        sel_next   = P_A1;
        state_next = ST_MAG;
      end
      ST_MAG:  state_next = ST_MLO;
      ST_MLO:  state_next = ST_MHI;
      ST_MHI:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_ADD;
      ST_ADD: begin
        if (sel == P_A2) begin
          state_next = ST_SATW;
        end else if (sel == P_B2) begin
          state_next = ST_SATY;
        end else begin
          sel_next   = sel + 3'd1;
          state_next = ST_MAG;
        end
      end
      ST_SATW: begin
        sel_next   = P_B0;
        state_next = ST_MAG;
      end
      ST_SATY: state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= P_A1;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    cmd.load_in    = (state == ST_IDLE) && in_valid;
    cmd.load_state = (state == ST_LOAD);
    cmd.mag        = (state == ST_MAG);
    cmd.mul_lo     = (state == ST_MLO);
    cmd.mul_hi     = (state == ST_MHI);
    cmd.sum        = (state == ST_SUM);
    cmd.add        = (state == ST_ADD);
    cmd.sel        = sel;
    cmd.sat_w      = (state == ST_SATW);
    cmd.sat_y      = (state == ST_SATY);
    cmd.out_load   = (state == ST_DONE) && status.out_free;
  end

  `MBF_ASSERT_NEXT(a_active_goes_load, clk, rst, (state == ST_IDLE) && in_valid && status.in_active, state == ST_LOAD, "active sample did not start filtering")
  `MBF_ASSERT_NEXT(a_feedback_then_satw, clk, rst, (state == ST_ADD) && (sel == P_A2), state == ST_SATW, "w not saturated after feedback products")
  `MBF_ASSERT_IMPL(a_sel_in_range, clk, rst, state == ST_MAG, sel <= P_B2, "product select out of range")
  `MBF_ASSERT_NEXT(a_done_holds, clk, rst, (state == ST_DONE) && !status.out_free, state == ST_DONE, "result dropped while output stalled")

endmodule

>>> rtl/core/multichannel_biquad_filter_core.sv
// ----------------------------------------------------------------------------
// multichannel_biquad_filter_core
// Direct form II biquad with per-channel state and shared coefficients.
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries one signed Q1.23 sample, s_tuser its channel.
// Output stream: m_tdata carries the filtered sample, m_tuser the same channel.
// Registers over APB: b0, b1, b2, a1, a2 (Q4.28), active channel count and
// flush threshold, at byte addresses 0x00 to 0x18.
// A filtered sample runs five coefficient*state products through one shared
// 32x32 multiplier, each through magnitude, low half, high half, combine and
// accumulate steps, plus load and two saturation steps. A new sample is taken
// only once the previous one has been handed to the output register.
// A sample on an inactive channel passes through unchanged, going straight
// from the input transaction to the done step and the output register.
// Reset restores the default coefficients (b0 = 1.0) and clears all channel
// state at once through per-channel valid bits; no clearing pass is needed.
// The result sits in an output register; the next sample is accepted and
// processed while it waits, and holds in the final step while m_tready is low.
// ----------------------------------------------------------------------------
module multichannel_biquad_filter_core import mbf_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
  parameter int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [TDATA_W-1:0]  s_tdata,   // sample_in
  input  logic [CH_W-1:0]     s_tuser,   // channel
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [TDATA_W-1:0]  m_tdata,   // sample_out
  output logic [CH_W-1:0]     m_tuser    // channel_out
);

  logic [NUM_PROD-1:0][COEF_WIDTH-1:0] coefs;
  logic [ACT_W-1:0]                    active_channels;
  logic [THR_W-1:0]                    flush_threshold;
  mbf_cmd_t                            cmd;
  mbf_status_t                         status;
  logic [SAMPLE_WIDTH-1:0]             out_sample;

  mbf_regs #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .coefs           (coefs),
    .active_channels (active_channels),
    .flush_threshold (flush_threshold)
  );

  mbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mbf_dp #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .coefs           (coefs),
    .active_channels (active_channels),
    .flush_threshold (flush_threshold),
    .in_ch           (s_tuser),
    .in_sample       (s_tdata[SAMPLE_WIDTH-1:0]),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_ch          (m_tuser),
    .out_sample      (out_sample)
  );

  assign m_tdata = TDATA_W'(out_sample);

endmodule
